// ----- src/assert_macros.svh -----
// Assertion macros shared by the resend window RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define UIRW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uirw: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define UIRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uirw: next-cycle check failed");

`endif

// ----- src/uirw_pkg.sv -----
// Types and constants shared by the resend window modules.
package uirw_pkg;

  localparam int FRAME_W   = 32;
  localparam int WORD_W    = 32;
  localparam int MOD_CNT_W = $clog2(FRAME_W);

  typedef enum logic [1:0] {
    ACT_RECORD = 2'd0,
    ACT_ACK    = 2'd1,
    ACT_SEND   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  localparam logic [1:0] ACK_FUTURE   = 2'd0;
  localparam logic [1:0] ACK_STALE    = 2'd1;
  localparam logic [1:0] ACK_ADVANCED = 2'd2;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACK_A,
    ST_ACK_B,
    ST_ACK_C,
    ST_SOLO,
    ST_FIRST_A,
    ST_FIRST_B,
    ST_FIRST_C,
    ST_MOD,
    ST_WRITE,
    ST_READ,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] generation;
    logic [FRAME_W-1:0] marker;
    logic               bundle;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [FRAME_W-1:0] generation;
    logic [FRAME_W-1:0] frame;
    logic [WORD_W-1:0]  input_word;
    logic [1:0]         status;
    logic               ack_valid;
    logic [FRAME_W-1:0] ack_frame;
    logic               last;
  } res_t;

endpackage

// ----- src/unacked_input_resend_window_top.sv -----
// Top level of the unacked input resend window: config port and wiring.
// Record maps the frame to a slot, bit-serially unless RING_DEPTH is a power of
//   two, and writes it; ack compares, then emits; unbundled send emits at once;
//   bundled send walks the entries; in_stall stays high until the item is done.
// Pace is set by the single shared compare unit and the ring's one registered read
//   port: each bundled entry takes a read step and a compare/emit step.
// After reset a clearing pass over every ring slot resets the ring; in_stall is high.
module unacked_input_resend_window_top #(
  parameter int RING_DEPTH  = 64,
  parameter int MAX_ENTRIES = 32,
  parameter int INPUT_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // APB-style config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_frame_number,
  input  logic [31:0] in_input_word,
  input  logic [31:0] in_acked_frame_in,
  input  logic [31:0] in_last_sent_frame,
  input  logic        in_ack_carry_valid,
  input  logic [31:0] in_ack_carry_frame,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [31:0] out_entry_generation,
  output logic [31:0] out_entry_frame,
  output logic [31:0] out_entry_input,
  output logic [1:0]  out_ack_status,
  output logic        out_attached_ack_valid,
  output logic [31:0] out_attached_ack_frame,
  output logic        out_last_of_run
);

  // stored input width: inputs beyond 32 bits are cut to the port width anyway
  localparam int IN_W = (INPUT_BITS < uirw_pkg::WORD_W) ? INPUT_BITS : uirw_pkg::WORD_W;
  localparam int AW   = $clog2(RING_DEPTH);
  localparam int DW   = 1 + uirw_pkg::FRAME_W + IN_W;   // {valid, tag, input}

  // register map, one 32-bit word each
  localparam logic [1:0] REG_GENERATION = 2'd0;
  localparam logic [1:0] REG_MARKER     = 2'd1;
  localparam logic [1:0] REG_BUNDLE     = 2'd2;

  uirw_pkg::cfg_t cfg_r, cfg_nxt;
  uirw_pkg::res_t res;

  logic                         cfg_wr;
  logic [1:0]                   reg_idx;

  logic                         ring_we;
  logic [AW-1:0]                ring_waddr;
  logic [DW-1:0]                ring_wdata;
  logic                         ring_re;
  logic [AW-1:0]                ring_raddr;
  logic [DW-1:0]                ring_rdata;

  logic [uirw_pkg::FRAME_W-1:0] cmp_a;
  logic [uirw_pkg::FRAME_W-1:0] cmp_b;
  logic                         cmp_lt;
  logic                         cmp_eq;
  logic [uirw_pkg::FRAME_W-1:0] cmp_inc;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  // write lands on the access-phase beat; indexes past the map are dropped
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_GENERATION: cfg_nxt.generation = pwdata;
        REG_MARKER:     cfg_nxt.marker     = pwdata;
        REG_BUNDLE:     cfg_nxt.bundle     = pwdata[0];
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GENERATION: prdata = cfg_r.generation;
      REG_MARKER:     prdata = cfg_r.marker;
      REG_BUNDLE:     prdata = {31'b0, cfg_r.bundle};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.generation <= '0;
      cfg_r.marker     <= '1;   // "nothing sent yet"
      cfg_r.bundle     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer: owns the ring pointer walk, ack state and the result register
  uirw_seq #(
    .RING_DEPTH  (RING_DEPTH),
    .MAX_ENTRIES (MAX_ENTRIES),
    .IN_W        (IN_W),
    .AW          (AW),
    .DW          (DW)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_frame_number    (in_frame_number),
    .in_input_word      (in_input_word),
    .in_acked_frame_in  (in_acked_frame_in),
    .in_last_sent_frame (in_last_sent_frame),
    .in_ack_carry_valid (in_ack_carry_valid),
    .in_ack_carry_frame (in_ack_carry_frame),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_res            (res),
    .ring_we            (ring_we),
    .ring_waddr         (ring_waddr),
    .ring_wdata         (ring_wdata),
    .ring_re            (ring_re),
    .ring_raddr         (ring_raddr),
    .ring_rdata         (ring_rdata),
    .cmp_a              (cmp_a),
    .cmp_b              (cmp_b),
    .cmp_lt             (cmp_lt),
    .cmp_eq             (cmp_eq),
    .cmp_inc            (cmp_inc)
  );

  // tagged ring of recorded inputs
  uirw_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (ring_wdata),
    .rd_en   (ring_re),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  // the one compare/increment unit that all compare steps share
  uirw_cmp u_cmp (
    .cmp_a   (cmp_a),
    .cmp_b   (cmp_b),
    .cmp_lt  (cmp_lt),
    .cmp_eq  (cmp_eq),
    .cmp_inc (cmp_inc)
  );

  assign out_result_kind        = res.kind;
  assign out_entry_generation   = res.generation;
  assign out_entry_frame        = res.frame;
  assign out_entry_input        = res.input_word;
  assign out_ack_status         = res.status;
  assign out_attached_ack_valid = res.ack_valid;
  assign out_attached_ack_frame = res.ack_frame;
  assign out_last_of_run        = res.last;

endmodule

// ----- src/uirw_cmp.sv -----
// Shared 32-bit compare and increment unit.
module uirw_cmp (
  input  logic [uirw_pkg::FRAME_W-1:0] cmp_a,
  input  logic [uirw_pkg::FRAME_W-1:0] cmp_b,
  output logic                         cmp_lt,
  output logic                         cmp_eq,
  output logic [uirw_pkg::FRAME_W-1:0] cmp_inc
);

  assign cmp_lt  = (cmp_a < cmp_b);
  assign cmp_eq  = (cmp_a == cmp_b);
  assign cmp_inc = cmp_a + 1'b1;

endmodule

// ----- src/uirw_ring.sv -----
// Frame ring memory: one write port, one registered read port.
module uirw_ring #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 65
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/uirw_seq.sv -----
// Sequencer and datapath: record, ack, send walk and result register.
`include "assert_macros.svh"

module uirw_seq #(
  parameter int RING_DEPTH  = 64,
  parameter int MAX_ENTRIES = 32,
  parameter int IN_W        = 32,
  parameter int AW          = $clog2(RING_DEPTH),
  parameter int DW          = 1 + uirw_pkg::FRAME_W + IN_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  uirw_pkg::cfg_t               cfg,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [uirw_pkg::FRAME_W-1:0] in_frame_number,
  input  logic [uirw_pkg::WORD_W-1:0]  in_input_word,
  input  logic [uirw_pkg::FRAME_W-1:0] in_acked_frame_in,
  input  logic [uirw_pkg::FRAME_W-1:0] in_last_sent_frame,
  input  logic                         in_ack_carry_valid,
  input  logic [uirw_pkg::FRAME_W-1:0] in_ack_carry_frame,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output uirw_pkg::res_t               out_res,
  // ring
  output logic                         ring_we,
  output logic [AW-1:0]                ring_waddr,
  output logic [DW-1:0]                ring_wdata,
  output logic                         ring_re,
  output logic [AW-1:0]                ring_raddr,
  input  logic [DW-1:0]                ring_rdata,
  // shared compare unit
  output logic [uirw_pkg::FRAME_W-1:0] cmp_a,
  output logic [uirw_pkg::FRAME_W-1:0] cmp_b,
  input  logic                         cmp_lt,
  input  logic                         cmp_eq,
  input  logic [uirw_pkg::FRAME_W-1:0] cmp_inc
);

  localparam int FRAME_W   = uirw_pkg::FRAME_W;
  localparam int WORD_W    = uirw_pkg::WORD_W;
  localparam int MOD_CNT_W = uirw_pkg::MOD_CNT_W;
  localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam bit IS_POW2   = ((RING_DEPTH & (RING_DEPTH - 1)) == 0);

  uirw_pkg::state_t state_r, state_nxt;

  // latched item
  uirw_pkg::action_t    act_r, act_nxt;
  logic [FRAME_W-1:0]   frame_r, frame_nxt;
  logic [IN_W-1:0]      word_r, word_nxt;
  logic [FRAME_W-1:0]   ack_in_r, ack_in_nxt;
  logic [FRAME_W-1:0]   last_sent_r, last_sent_nxt;
  logic                 carry_v_r, carry_v_nxt;
  logic [FRAME_W-1:0]   carry_f_r, carry_f_nxt;

  // block state
  logic [FRAME_W-1:0]   oldest_r, oldest_nxt;
  logic                 nonempty_r, nonempty_nxt;
  logic                 ack_valid_r, ack_valid_nxt;
  logic [FRAME_W-1:0]   ack_value_r, ack_value_nxt;

  // walk and reduction
  logic [FRAME_W-1:0]   e_r, e_nxt;
  logic                 fut_r, fut_nxt;
  logic                 end_r, end_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;
  logic [FRAME_W-1:0]   mod_val_r, mod_val_nxt;
  logic [MOD_CNT_W-1:0] mod_cnt_r, mod_cnt_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  uirw_pkg::res_t       out_res_r, out_res_nxt;

  logic                 accept;
  logic                 out_free;
  logic                 mod_done;
  logic                 slot_last;
  logic [AW-1:0]        slot_inc;
  logic [AW:0]          mod_t;
  logic [AW:0]          mod_red;
  logic                 rd_valid;
  logic [FRAME_W-1:0]   rd_tag;
  logic [IN_W-1:0]      rd_in;
  logic                 stale;

  assign in_stall  = (state_r != uirw_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign slot_last = (slot_r == AW'(RING_DEPTH - 1));
  assign slot_inc  = slot_last ? '0 : slot_r + 1'b1;

  // one bit of frame mod RING_DEPTH per cycle
  assign mod_t    = {slot_r, mod_val_r[FRAME_W-1]};
  assign mod_red  = (mod_t >= (AW+1)'(RING_DEPTH)) ? mod_t - (AW+1)'(RING_DEPTH) : mod_t;
  assign mod_done = IS_POW2 || (mod_cnt_r == MOD_CNT_W'(FRAME_W - 1));

  assign rd_valid = ring_rdata[DW-1];
  assign rd_tag   = ring_rdata[IN_W +: FRAME_W];
  assign rd_in    = ring_rdata[IN_W-1:0];

  assign stale = ack_valid_r && !cmp_lt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      uirw_pkg::ST_CLEAR: begin
        if (slot_last) state_nxt = uirw_pkg::ST_IDLE;
      end
      uirw_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (uirw_pkg::action_t'(in_action))
            uirw_pkg::ACT_RECORD: state_nxt = uirw_pkg::ST_MOD;
            uirw_pkg::ACT_ACK:    state_nxt = uirw_pkg::ST_ACK_A;
            uirw_pkg::ACT_SEND:   state_nxt = cfg.bundle ? uirw_pkg::ST_FIRST_A
                                                         : uirw_pkg::ST_SOLO;
            uirw_pkg::ACT_CLEAR:  state_nxt = uirw_pkg::ST_IDLE;
            default:              state_nxt = uirw_pkg::ST_IDLE;
          endcase
        end
      end
      uirw_pkg::ST_ACK_A:   state_nxt = uirw_pkg::ST_ACK_B;
      uirw_pkg::ST_ACK_B:   state_nxt = uirw_pkg::ST_ACK_C;
      uirw_pkg::ST_ACK_C: begin
        if (out_free) state_nxt = uirw_pkg::ST_IDLE;
      end
      uirw_pkg::ST_SOLO: begin
        if (out_free) state_nxt = uirw_pkg::ST_IDLE;
      end
      uirw_pkg::ST_FIRST_A: state_nxt = uirw_pkg::ST_FIRST_B;
      uirw_pkg::ST_FIRST_B: state_nxt = uirw_pkg::ST_FIRST_C;
      uirw_pkg::ST_FIRST_C: state_nxt = uirw_pkg::ST_MOD;
      uirw_pkg::ST_MOD: begin
        if (mod_done) begin
          state_nxt = (act_r == uirw_pkg::ACT_RECORD) ? uirw_pkg::ST_WRITE
                                                      : uirw_pkg::ST_READ;
        end
      end
      uirw_pkg::ST_WRITE:   state_nxt = uirw_pkg::ST_IDLE;
      uirw_pkg::ST_READ:    state_nxt = uirw_pkg::ST_CHECK;
      uirw_pkg::ST_CHECK: begin
        if (out_free) state_nxt = end_r ? uirw_pkg::ST_IDLE : uirw_pkg::ST_READ;
      end
      default:              state_nxt = uirw_pkg::ST_IDLE;
    endcase
  end

  // datapath, ring and compare unit drive
  always_comb begin
    act_nxt       = act_r;
    frame_nxt     = frame_r;
    word_nxt      = word_r;
    ack_in_nxt    = ack_in_r;
    last_sent_nxt = last_sent_r;
    carry_v_nxt   = carry_v_r;
    carry_f_nxt   = carry_f_r;
    oldest_nxt    = oldest_r;
    nonempty_nxt  = nonempty_r;
    ack_valid_nxt = ack_valid_r;
    ack_value_nxt = ack_value_r;
    e_nxt         = e_r;
    fut_nxt       = fut_r;
    end_nxt       = end_r;
    slot_nxt      = slot_r;
    mod_val_nxt   = mod_val_r;
    mod_cnt_nxt   = mod_cnt_r;
    cnt_nxt       = cnt_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && out_stall;

    ring_we    = 1'b0;
    ring_waddr = slot_r;
    ring_wdata = {1'b1, frame_r, word_r};
    ring_re    = 1'b0;
    ring_raddr = slot_r;
    cmp_a      = e_r;
    cmp_b      = frame_r;

    unique case (state_r)
      uirw_pkg::ST_CLEAR: begin
        ring_we    = 1'b1;
        ring_wdata = '0;
        slot_nxt   = slot_inc;
      end
      uirw_pkg::ST_IDLE: begin
        if (accept) begin
          act_nxt       = uirw_pkg::action_t'(in_action);
          frame_nxt     = in_frame_number;
          word_nxt      = in_input_word[IN_W-1:0];
          ack_in_nxt    = in_acked_frame_in;
          last_sent_nxt = in_last_sent_frame;
          carry_v_nxt   = in_ack_carry_valid;
          carry_f_nxt   = in_ack_carry_valid ? in_ack_carry_frame : '0;
          mod_val_nxt   = in_frame_number;
          mod_cnt_nxt   = '0;
          slot_nxt      = '0;
          cnt_nxt       = '0;
          if (uirw_pkg::action_t'(in_action) == uirw_pkg::ACT_CLEAR) begin
            ack_valid_nxt = 1'b0;
          end
        end
      end
      uirw_pkg::ST_ACK_A: begin
        cmp_a   = last_sent_r;
        cmp_b   = cfg.marker;
        fut_nxt = cmp_eq;
      end
      uirw_pkg::ST_ACK_B: begin
        cmp_a   = last_sent_r;
        cmp_b   = ack_in_r;
        fut_nxt = fut_r || cmp_lt;
      end
      uirw_pkg::ST_ACK_C: begin
        cmp_a = ack_value_r;
        cmp_b = ack_in_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '0;
          out_res_nxt.kind = uirw_pkg::KIND_ACK;
          out_res_nxt.last = 1'b1;
          if (fut_r) begin
            out_res_nxt.status = uirw_pkg::ACK_FUTURE;
          end else if (stale) begin
            out_res_nxt.status = uirw_pkg::ACK_STALE;
          end else begin
            out_res_nxt.status = uirw_pkg::ACK_ADVANCED;
            ack_valid_nxt      = 1'b1;
            ack_value_nxt      = ack_in_r;
          end
        end
      end
      uirw_pkg::ST_SOLO: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_res_nxt            = '0;
          out_res_nxt.kind       = uirw_pkg::KIND_ENTRY;
          out_res_nxt.generation = cfg.generation;
          out_res_nxt.frame      = frame_r;
          out_res_nxt.input_word = WORD_W'(word_r);
          out_res_nxt.last       = 1'b1;
        end
      end
      uirw_pkg::ST_FIRST_A: begin
        cmp_a = ack_value_r;
        cmp_b = frame_r;
        if (ack_valid_r && cmp_lt) begin
          e_nxt = cmp_inc;
        end else if (!ack_valid_r && nonempty_r) begin
          e_nxt = oldest_r;
        end else begin
          e_nxt = frame_r;
        end
      end
      uirw_pkg::ST_FIRST_B: begin
        cmp_a = e_r;
        cmp_b = oldest_r;
        if (nonempty_r && cmp_lt) e_nxt = oldest_r;
      end
      uirw_pkg::ST_FIRST_C: begin
        cmp_a       = frame_r;
        cmp_b       = e_r;
        e_nxt       = cmp_lt ? frame_r : e_r;
        mod_val_nxt = cmp_lt ? frame_r : e_r;
        mod_cnt_nxt = '0;
        slot_nxt    = '0;
      end
      uirw_pkg::ST_MOD: begin
        if (IS_POW2) begin
          slot_nxt = mod_val_r[AW-1:0];
        end else begin
          slot_nxt    = mod_red[AW-1:0];
          mod_val_nxt = {mod_val_r[FRAME_W-2:0], 1'b0};
          mod_cnt_nxt = mod_cnt_r + 1'b1;
        end
      end
      uirw_pkg::ST_WRITE: begin
        ring_we = 1'b1;
        cmp_a   = frame_r;
        cmp_b   = oldest_r;
        if (!nonempty_r || cmp_lt) oldest_nxt = frame_r;
        nonempty_nxt = 1'b1;
      end
      uirw_pkg::ST_READ: begin
        ring_re = 1'b1;
        cmp_a   = e_r;
        cmp_b   = frame_r;
        end_nxt = cmp_eq || (&e_r) || (cnt_r == CNT_W'(MAX_ENTRIES - 1));
      end
      uirw_pkg::ST_CHECK: begin
        cmp_a = e_r;
        cmp_b = rd_tag;
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_res_nxt.kind       = uirw_pkg::KIND_ENTRY;
          out_res_nxt.generation = cfg.generation;
          out_res_nxt.frame      = e_r;
          out_res_nxt.input_word = (rd_valid && cmp_eq) ? WORD_W'(rd_in) : WORD_W'(word_r);
          out_res_nxt.status     = uirw_pkg::ACK_FUTURE;
          out_res_nxt.ack_valid  = carry_v_r;
          out_res_nxt.ack_frame  = carry_f_r;
          out_res_nxt.last       = end_r;
          e_nxt                  = cmp_inc;
          slot_nxt               = slot_inc;
          cnt_nxt                = cnt_r + 1'b1;
        end
      end
      default: begin
        slot_nxt = slot_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uirw_pkg::ST_CLEAR;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      oldest_r    <= '0;
      nonempty_r  <= 1'b0;
      ack_valid_r <= 1'b0;
      ack_value_r <= '0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
      oldest_r    <= oldest_nxt;
      nonempty_r  <= nonempty_nxt;
      ack_valid_r <= ack_valid_nxt;
      ack_value_r <= ack_value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    frame_r     <= frame_nxt;
    word_r      <= word_nxt;
    ack_in_r    <= ack_in_nxt;
    last_sent_r <= last_sent_nxt;
    carry_v_r   <= carry_v_nxt;
    carry_f_r   <= carry_f_nxt;
    e_r         <= e_nxt;
    fut_r       <= fut_nxt;
    end_r       <= end_nxt;
    mod_val_r   <= mod_val_nxt;
    mod_cnt_r   <= mod_cnt_nxt;
    cnt_r       <= cnt_nxt;
    out_res_r   <= out_res_nxt;
  end

  `UIRW_ASSERT_NOW(a_quiet_in_clear, clk, rst_n, state_r == uirw_pkg::ST_CLEAR, !out_valid_r)
  `UIRW_ASSERT_NOW(a_ack_ends_run, clk, rst_n, out_valid_r && (out_res_r.kind == uirw_pkg::KIND_ACK), out_res_r.last)
  `UIRW_ASSERT_NEXT(a_ack_set_src, clk, rst_n, !ack_valid_r && (state_r != uirw_pkg::ST_ACK_C), !ack_valid_r)
  `UIRW_ASSERT_NOW(a_walk_bounded, clk, rst_n, state_r == uirw_pkg::ST_CHECK, end_r || (cnt_r != CNT_W'(MAX_ENTRIES - 1)))

endmodule
